### hdl/esc_pkg.sv
`timescale 1ns / 1ps

package esc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned RawW = 20;
  localparam int unsigned ValW = 33;
  localparam int unsigned DivSteps = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TEMP      = 3'd0,
    REG_PRESS_LO  = 3'd1,
    REG_PRESS_MID = 3'd2,
    REG_PRESS_HI  = 3'd3,
    REG_HUM       = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_TEMP  = 2'd0,
    KIND_PRESS = 2'd1,
    KIND_HUM   = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_HUM_HIGH = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    DIV_IDLE = 2'd0,
    DIV_RUN  = 2'd1,
    DIV_DONE = 2'd2
  } div_state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

### hdl/esc_divider.sv
`timescale 1ns / 1ps

// restoring unsigned divider, one quotient bit per cycle
module esc_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  esc_pkg::div_req_t req_i,
  output esc_pkg::div_rsp_t rsp_o
);

  esc_pkg::div_state_e state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [32:0] trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= esc_pkg::DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    trial   = {rem_q, quo_q[31]} - {1'b0, den_q};
    case (state_q)
      esc_pkg::DIV_IDLE: begin
        if (req_i.start) begin
          quo_d   = req_i.dividend;
          den_d   = req_i.divisor;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = esc_pkg::DIV_RUN;
        end
      end
      esc_pkg::DIV_RUN: begin
        if (!trial[32]) begin
          rem_d = trial[31:0];
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = {rem_q[30:0], quo_q[31]};
          quo_d = {quo_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(esc_pkg::DivSteps - 1)) state_d = esc_pkg::DIV_DONE;
      end
      esc_pkg::DIV_DONE: state_d = esc_pkg::DIV_IDLE;
      default: state_d = esc_pkg::DIV_IDLE;
    endcase
  end

  assign rsp_o.done     = (state_q == esc_pkg::DIV_DONE);
  assign rsp_o.quotient = quo_q;

endmodule

### hdl/esc_core.sv
`timescale 1ns / 1ps

// step sequencer around one shared 32x32 multiplier
module esc_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [1:0]                    kind_i,
  input  logic [esc_pkg::RawW-1:0]      raw_i,
  input  logic [47:0]                   tcal_i,
  input  logic [63:0]                   pcal_lo_i,
  input  logic [63:0]                   pcal_mid_i,
  input  logic [15:0]                   pcal_hi_i,
  input  logic [63:0]                   hcal_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [esc_pkg::ValW-1:0]      value_o,
  output logic [1:0]                    status_o
);

  logic [5:0]         step_q, step_d;
  logic               run_q, run_d;
  logic [1:0]         kind_q;
  logic signed [31:0] adc_q;
  logic signed [31:0] fine_q, fine_d;
  logic signed [31:0] r0_q, r1_q, r2_q, r3_q, r4_q;
  logic signed [31:0] r0_d, r1_d, r2_d, r3_d, r4_d;
  logic signed [31:0] ma, mb, prod;
  logic               done_q, done_d;
  logic [esc_pkg::ValW-1:0] val_q, val_d;
  logic [1:0]         st_q, st_d;
  esc_pkg::div_req_t  dreq;
  esc_pkg::div_rsp_t  drsp;

  logic signed [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic signed [31:0] h1, h2, h3, h4, h5, h6;
  logic signed [31:0] pct;

  assign t1 = {16'd0, tcal_i[15:0]};
  assign t2 = {{16{tcal_i[31]}}, tcal_i[31:16]};
  assign t3 = {{16{tcal_i[47]}}, tcal_i[47:32]};
  assign p1 = {16'd0, pcal_lo_i[15:0]};
  assign p2 = {{16{pcal_lo_i[31]}}, pcal_lo_i[31:16]};
  assign p3 = {{16{pcal_lo_i[47]}}, pcal_lo_i[47:32]};
  assign p4 = {{16{pcal_lo_i[63]}}, pcal_lo_i[63:48]};
  assign p5 = {{16{pcal_mid_i[15]}}, pcal_mid_i[15:0]};
  assign p6 = {{16{pcal_mid_i[31]}}, pcal_mid_i[31:16]};
  assign p7 = {{16{pcal_mid_i[47]}}, pcal_mid_i[47:32]};
  assign p8 = {{16{pcal_mid_i[63]}}, pcal_mid_i[63:48]};
  assign p9 = {{16{pcal_hi_i[15]}}, pcal_hi_i};
  assign h1 = {24'd0, hcal_i[7:0]};
  assign h2 = {{16{hcal_i[23]}}, hcal_i[23:8]};
  assign h3 = {24'd0, hcal_i[31:24]};
  assign h4 = {{20{hcal_i[43]}}, hcal_i[43:32]};
  assign h5 = {{20{hcal_i[55]}}, hcal_i[55:44]};
  assign h6 = {{24{hcal_i[63]}}, hcal_i[63:56]};

  // the one multiplier, low 32 bits only
  assign prod = ma * mb;

  esc_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
      fine_q <= '0;
    end else begin
      step_q <= step_d;
      run_q  <= run_d;
      done_q <= done_d;
      fine_q <= fine_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !run_q) begin
      kind_q <= kind_i;
      adc_q  <= (kind_i == esc_pkg::KIND_HUM) ? {16'd0, raw_i[15:0]} : {12'd0, raw_i};
    end
    r0_q  <= r0_d;
    r1_q  <= r1_d;
    r2_q  <= r2_d;
    r3_q  <= r3_d;
    r4_q  <= r4_d;
    val_q <= val_d;
    st_q  <= st_d;
  end

  assign pct = r0_q >>> 22;

  always_comb begin
    step_d = step_q;
    run_d  = run_q;
    done_d = 1'b0;
    fine_d = fine_q;
    r0_d = r0_q; r1_d = r1_q; r2_d = r2_q; r3_d = r3_q; r4_d = r4_q;
    val_d = val_q;
    st_d  = st_q;
    ma = '0;
    mb = '0;
    dreq.start    = 1'b0;
    dreq.dividend = r1_q;
    dreq.divisor  = r0_q;
    if (!run_q) begin
      if (start_i) begin
        run_d  = 1'b1;
        step_d = '0;
      end
    end else begin
      step_d = step_q + 6'd1;
      case (kind_q)
        esc_pkg::KIND_TEMP: begin
          case (step_q)
            6'd0: begin
              ma = (adc_q >>> 3) - (t1 <<< 1); mb = t2;
              r0_d = prod >>> 11;
            end
            6'd1: begin
              ma = (adc_q >>> 4) - t1; mb = (adc_q >>> 4) - t1;
              r1_d = prod >>> 12;
            end
            6'd2: begin
              ma = r1_q; mb = t3;
              fine_d = r0_q + (prod >>> 14);
            end
            default: begin
              ma = fine_q; mb = 32'sd5;
              r0_d  = (prod + 32'sd128) >>> 8;
              val_d = {r0_d[31], r0_d};
              st_d  = esc_pkg::ST_OK;
              run_d = 1'b0; done_d = 1'b1;
            end
          endcase
        end
        esc_pkg::KIND_PRESS: begin
          case (step_q)
            6'd0: begin
              r0_d = (fine_q >>> 1) - 32'sd64000;
            end
            6'd1: begin
              ma = r0_q >>> 2; mb = r0_q >>> 2;
              r1_d = prod;  // sq
            end
            6'd2: begin
              ma = r1_q >>> 11; mb = p6;
              r2_d = prod;
            end
            6'd3: begin
              ma = r0_q; mb = p5;
              r2_d = ((r2_q + (prod <<< 1)) >>> 2) + (p4 <<< 16);
            end
            6'd4: begin
              ma = p3; mb = r1_q >>> 13;
              r3_d = prod >>> 3;
            end
            6'd5: begin
              ma = p2; mb = r0_q;
              r3_d = (r3_q + (prod >>> 1)) >>> 18;
            end
            6'd6: begin
              ma = 32'sd32768 + r3_q; mb = p1;
              r0_d = prod >>> 15;  // divisor
              r1_d = 32'sd1048576 - adc_q - (r2_q >>> 12);
            end
            6'd7: begin
              ma = r1_q; mb = 32'sd3125;
              r1_d = prod;
              if (r0_q == 0) begin
                val_d = '0; st_d = esc_pkg::ST_DIV_ZERO;
                run_d = 1'b0; done_d = 1'b1;
              end
            end
            6'd8: begin
              r4_d = {31'd0, r1_q[31]};
              if (!r1_q[31]) r1_d = r1_q <<< 1;
              dreq.start    = 1'b1;
              dreq.dividend = r1_q[31] ? r1_q : (r1_q <<< 1);
            end
            6'd9: begin
              step_d = step_q;
              if (drsp.done) begin
                step_d = 6'd10;
                r1_d = r4_q[0] ? (drsp.quotient <<< 1) : drsp.quotient;
              end
            end
            6'd10: begin
              ma = {3'd0, r1_q[31:3]}; mb = {3'd0, r1_q[31:3]};
              r2_d = {13'd0, prod[31:13]};
            end
            6'd11: begin
              ma = p9; mb = r2_q;
              r3_d = prod >>> 12;
            end
            6'd12: begin
              ma = {2'd0, r1_q[31:2]}; mb = p8;
              r3_d = r1_q + ((r3_q + (prod >>> 13) + p7) >>> 4);
            end
            default: begin
              val_d = {1'b0, r3_q}; st_d = esc_pkg::ST_OK;
              run_d = 1'b0; done_d = 1'b1;
            end
          endcase
        end
        esc_pkg::KIND_HUM: begin
          case (step_q)
            6'd0: begin
              r0_d = fine_q - 32'sd76800;
            end
            6'd1: begin
              ma = h5; mb = r0_q;
              r1_d = ((((adc_q <<< 14) - (h4 <<< 20)) - prod) + 32'sd16384) >>> 15;
            end
            6'd2: begin
              ma = r0_q; mb = h6;
              r2_d = prod >>> 10;
            end
            6'd3: begin
              ma = r0_q; mb = h3;
              r3_d = (prod >>> 11) + 32'sd32768;
            end
            6'd4: begin
              ma = r2_q; mb = r3_q;
              r2_d = (prod >>> 10) + 32'sd2097152;
            end
            6'd5: begin
              ma = r2_q; mb = h2;
              r2_d = (prod + 32'sd8192) >>> 14;
            end
            6'd6: begin
              ma = r1_q; mb = r2_q;
              r0_d = prod;  // x
            end
            6'd7: begin
              ma = r0_q >>> 15; mb = r0_q >>> 15;
              r3_d = prod >>> 7;
            end
            6'd8: begin
              ma = r3_q; mb = h1;
              r0_d = r0_q - (prod >>> 4);
              if (r0_d < 0) r0_d = '0;
              if (r0_d > 32'sd419430400) r0_d = 32'sd419430400;
            end
            default: begin
              val_d = {1'b0, pct};
              st_d  = (pct > 32'sd99) ? esc_pkg::ST_HUM_HIGH : esc_pkg::ST_OK;
              run_d = 1'b0; done_d = 1'b1;
            end
          endcase
        end
        default: begin
          val_d = '0; st_d = esc_pkg::ST_OK;
          run_d = 1'b0; done_d = 1'b1;
        end
      endcase
    end
  end

  assign busy_o   = run_q;
  assign done_o   = done_q;
  assign value_o  = val_q;
  assign status_o = st_q;

endmodule

### hdl/env_sensor_compensation.sv
`timescale 1ns / 1ps
// throughput: one word at a time; the next word is taken once the result
// sits in the output register and that register is free or being read;
// pressure words wait longest, on the 32-step divider loop
// reset: asynchronous active low; calibration and fine temperature clear to zero
module env_sensor_compensation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // raw_sample[19:0]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // compensated_value[32:0]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [esc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [esc_pkg::CfgDataW-1:0] cfg_data_i
);

  logic [47:0] tcal_q;
  logic [63:0] plo_q, pmid_q, hcal_q;
  logic [15:0] phi_q;
  logic        busy, done, start, ovalid_q;
  logic [esc_pkg::ValW-1:0] value, oval_q;
  logic [1:0]  status, ost_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcal_q <= '0; plo_q <= '0; pmid_q <= '0; phi_q <= '0; hcal_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        esc_pkg::REG_TEMP:      tcal_q <= cfg_data_i[47:0];
        esc_pkg::REG_PRESS_LO:  plo_q  <= cfg_data_i;
        esc_pkg::REG_PRESS_MID: pmid_q <= cfg_data_i;
        esc_pkg::REG_PRESS_HI:  phi_q  <= cfg_data_i[15:0];
        esc_pkg::REG_HUM:       hcal_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a new word waits until the output register is free
  assign s_axis_tready = !busy && !done && (!ovalid_q || m_axis_tready);
  assign start = s_axis_tvalid && s_axis_tready;

  esc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .kind_i     (s_axis_tuser),
    .raw_i      (s_axis_tdata[esc_pkg::RawW-1:0]),
    .tcal_i     (tcal_q),
    .pcal_lo_i  (plo_q),
    .pcal_mid_i (pmid_q),
    .pcal_hi_i  (phi_q),
    .hcal_i     (hcal_q),
    .busy_o     (busy),
    .done_o     (done),
    .value_o    (value),
    .status_o   (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (done) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      oval_q <= value;
      ost_q  <= status;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {7'd0, oval_q};
  assign m_axis_tuser  = ost_q;

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SettleCycles = 60;

  typedef struct packed {
    logic [39:0] value;
    logic [1:0]  status;
  } reading_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_valid;
  logic        s_axis_tready;
  logic [23:0] s_data;
  logic [1:0]  s_user;
  logic        m_axis_tvalid;
  logic        m_ready;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready_o;
  logic [esc_pkg::CfgIdxW-1:0]  cfg_index;
  logic [esc_pkg::CfgDataW-1:0] cfg_data;

  env_sensor_compensation dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // predictor copy of the calibration and the fine temperature
  logic [47:0] cal_temp;
  logic [63:0] cal_press_lo;
  logic [63:0] cal_press_mid;
  logic [15:0] cal_press_hi;
  logic [63:0] cal_hum;
  longint      fine_temp;

  reading_t pending_readings[$];
  int unsigned cycles;
  int errors;
  int send_idle;
  int recv_idle;
  int stall_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic longint w32(longint x);
    return longint'(int'(x));
  endfunction

  function automatic longint mul32(longint a, longint b);
    return w32(a * b);
  endfunction

  function automatic reading_t comp_temp(longint adc);
    longint t1, t2, t3, a, v1, b, v2, deg;
    t1 = longint'(cal_temp[15:0]);
    t2 = longint'($signed(cal_temp[31:16]));
    t3 = longint'($signed(cal_temp[47:32]));
    a = w32((adc >>> 3) - w32(t1 << 1));
    v1 = mul32(a, t2) >>> 11;
    b = w32((adc >>> 4) - t1);
    v2 = mul32(mul32(b, b) >>> 12, t3) >>> 14;
    fine_temp = w32(v1 + v2);
    deg = w32(mul32(fine_temp, 5) + 128) >>> 8;
    return '{value: {7'b0, 33'(deg)}, status: esc_pkg::ST_OK};
  endfunction

  function automatic reading_t comp_press(longint adc);
    longint p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, sq;
    int unsigned p, dv, q;
    p1 = longint'(cal_press_lo[15:0]);
    p2 = longint'($signed(cal_press_lo[31:16]));
    p3 = longint'($signed(cal_press_lo[47:32]));
    p4 = longint'($signed(cal_press_lo[63:48]));
    p5 = longint'($signed(cal_press_mid[15:0]));
    p6 = longint'($signed(cal_press_mid[31:16]));
    p7 = longint'($signed(cal_press_mid[47:32]));
    p8 = longint'($signed(cal_press_mid[63:48]));
    p9 = longint'($signed(cal_press_hi));
    v1 = w32((fine_temp >>> 1) - 64000);
    sq = mul32(v1 >>> 2, v1 >>> 2);
    v2 = mul32(sq >>> 11, p6);
    v2 = w32(v2 + w32(mul32(v1, p5) << 1));
    v2 = w32((v2 >>> 2) + w32(p4 << 16));
    v1 = w32((mul32(p3, sq >>> 13) >>> 3) + (mul32(p2, v1) >>> 1)) >>> 18;
    v1 = mul32(w32(32768 + v1), p1) >>> 15;
    if (v1 == 0) return '{value: '0, status: esc_pkg::ST_DIV_ZERO};
    dv = 32'(v1);
    p = 32'(1048576 - adc);
    p = p - 32'(v2 >>> 12);
    p = p * 32'd3125;
    if (p < 32'h8000_0000) p = (p << 1) / dv;
    else p = (p / dv) * 32'd2;
    // square wraps at 32 bits before the shift
    q = 32'(longint'(p >> 3) * longint'(p >> 3));
    q = q >> 13;
    v1 = mul32(p9, w32(longint'(q))) >>> 12;
    v2 = mul32(w32(longint'(p >> 2)), p8) >>> 13;
    v1 = w32(w32(longint'(p)) + (w32(w32(v1 + v2) + p7) >>> 4));
    return '{value: {8'b0, 32'(v1)}, status: esc_pkg::ST_OK};
  endfunction

  function automatic reading_t comp_hum(longint adc);
    longint h1, h2, h3, h4, h5, h6, x, a, b, c, pct;
    h1 = longint'(cal_hum[7:0]);
    h2 = longint'($signed(cal_hum[23:8]));
    h3 = longint'(cal_hum[31:24]);
    h4 = longint'($signed(cal_hum[43:32]));
    h5 = longint'($signed(cal_hum[55:44]));
    h6 = longint'($signed(cal_hum[63:56]));
    x = w32(fine_temp - 76800);
    a = w32(w32(adc << 14) - w32(h4 << 20));
    a = w32(a - mul32(h5, x));
    a = w32(a + 16384) >>> 15;
    b = mul32(x, h6) >>> 10;
    c = w32((mul32(x, h3) >>> 11) + 32768);
    b = w32((mul32(b, c) >>> 10) + 2097152);
    b = w32(mul32(b, h2) + 8192) >>> 14;
    x = mul32(a, b);
    c = mul32(x >>> 15, x >>> 15) >>> 7;
    x = w32(x - (mul32(c, h1) >>> 4));
    if (x < 0) x = 0;
    if (x > 419430400) x = 419430400;
    pct = (x >> 12) / 1024;
    return '{value: {7'b0, 33'(pct)},
             status: (pct > 99) ? esc_pkg::ST_HUM_HIGH : esc_pkg::ST_OK};
  endfunction

  function automatic reading_t compensate(esc_pkg::kind_e kind, logic [19:0] raw);
    case (kind)
      esc_pkg::KIND_TEMP:  return comp_temp(longint'(raw));
      esc_pkg::KIND_PRESS: return comp_press(longint'(raw));
      esc_pkg::KIND_HUM:   return comp_hum(longint'(raw[15:0]));
      default:             return '{value: '0, status: esc_pkg::ST_OK};
    endcase
  endfunction

  // receiver side: check each accepted word, then pick the next ready
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && m_axis_tvalid && m_ready) begin
      if (pending_readings.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word value=%h status=%0d",
                                   m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_readings.pop_front();
        if (m_axis_tdata !== want.value || m_axis_tuser !== want.status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch value exp=%h got=%h status exp=%0d got=%0d",
                     want.value, m_axis_tdata, want.status, m_axis_tuser);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // valid stays up after the accept; the next send may drop it while idling, a drain drops it
  task automatic send_reading(esc_pkg::kind_e kind, logic [19:0] raw);
    while ($urandom_range(99) < send_idle) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user <= kind;
    s_data <= {4'b0, raw};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_readings.push_back(compensate(kind, raw));
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(esc_pkg::reg_idx_e idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      esc_pkg::REG_TEMP:      cal_temp = value[47:0];
      esc_pkg::REG_PRESS_LO:  cal_press_lo = value;
      esc_pkg::REG_PRESS_MID: cal_press_mid = value;
      esc_pkg::REG_PRESS_HI:  cal_press_hi = value[15:0];
      esc_pkg::REG_HUM:       cal_hum = value;
      default:                ;
    endcase
  endtask

  function automatic logic [15:0] jitter(logic [15:0] v);
    return v + 16'($signed($urandom_range(64)) - 32);
  endfunction

  // 0 typical factory set, 1 random, 2 all ones, 3 zeros
  task automatic load_calibration(int mode);
    logic [63:0] w [5];
    case (mode)
      0: begin
        w[0] = {16'd0, 16'hFC18, jitter(16'd26435), jitter(16'd27504)};
        w[1] = {jitter(16'd2855), jitter(16'd3024), jitter(16'hD643), jitter(16'd36477)};
        w[2] = {16'hC6F8, jitter(16'd15500), 16'hFFF9, jitter(16'd140)};
        w[3] = {48'b0, jitter(16'd6000)};
        w[4] = {8'd30, 12'd50, 12'd313, 8'd0, jitter(16'd362), 8'd75};
      end
      1: foreach (w[i]) w[i] = {$urandom, $urandom};
      2: foreach (w[i]) w[i] = '1;
      default: foreach (w[i]) w[i] = '0;
    endcase
    write_reg(esc_pkg::REG_TEMP, w[0]);
    write_reg(esc_pkg::REG_PRESS_LO, w[1]);
    write_reg(esc_pkg::REG_PRESS_MID, w[2]);
    write_reg(esc_pkg::REG_PRESS_HI, w[3]);
    write_reg(esc_pkg::REG_HUM, w[4]);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    // zero calibration: pressure divisor is zero, fine temperature still 0
    send_reading(esc_pkg::KIND_PRESS, 20'd415148);
    send_reading(esc_pkg::KIND_HUM, 20'h0ffff);
    send_reading(esc_pkg::KIND_TEMP, 20'hfffff);
    send_reading(esc_pkg::KIND_NONE, 20'hfffff);
    wait_drained();
  endtask

  task automatic test_directed();
    load_calibration(0);
    send_reading(esc_pkg::KIND_HUM, 20'd30000);
    send_reading(esc_pkg::KIND_PRESS, 20'd415148);
    send_reading(esc_pkg::KIND_TEMP, 20'd0);
    send_reading(esc_pkg::KIND_TEMP, 20'hfffff);
    send_reading(esc_pkg::KIND_TEMP, 20'd519888);
    send_reading(esc_pkg::KIND_PRESS, 20'd0);
    send_reading(esc_pkg::KIND_PRESS, 20'hfffff);
    send_reading(esc_pkg::KIND_PRESS, 20'd415148);
    send_reading(esc_pkg::KIND_HUM, 20'd0);
    send_reading(esc_pkg::KIND_HUM, 20'h0ffff);
    send_reading(esc_pkg::KIND_HUM, 20'hf0000);
    send_reading(esc_pkg::KIND_HUM, 20'd30000);
    send_reading(esc_pkg::KIND_NONE, 20'd519888);
    send_reading(esc_pkg::KIND_NONE, 20'd0);
    wait_drained();
    load_calibration(2);
    send_reading(esc_pkg::KIND_TEMP, 20'hfffff);
    send_reading(esc_pkg::KIND_PRESS, 20'hfffff);
    send_reading(esc_pkg::KIND_HUM, 20'h0ffff);
    send_reading(esc_pkg::KIND_TEMP, 20'd0);
    send_reading(esc_pkg::KIND_PRESS, 20'd0);
    send_reading(esc_pkg::KIND_HUM, 20'd0);
    wait_drained();
  endtask

  task automatic random_reading();
    esc_pkg::kind_e kind;
    logic [19:0] raw;
    int pick;
    pick = $urandom_range(19);
    kind = (pick == 0) ? esc_pkg::KIND_NONE : esc_pkg::kind_e'(pick % 3);
    raw = 20'($urandom);
    if ($urandom_range(2) != 0) begin
      case (kind)
        esc_pkg::KIND_TEMP:  raw = 20'($urandom_range(600000, 400000));
        esc_pkg::KIND_PRESS: raw = 20'($urandom_range(450000, 250000));
        esc_pkg::KIND_HUM:   raw = 20'($urandom_range(45000, 15000));
        default:             ;
      endcase
    end
    send_reading(kind, raw);
  endtask

  task automatic test_random_phase(int s_pct, int r_pct, int count);
    send_idle = s_pct;
    recv_idle = r_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 70 == 0) begin
        wait_drained();
        load_calibration((i / 70) % 4 == 3 ? 1 : (i / 70) % 4 == 2 ? 3 : (i / 70) % 2);
      end
      random_reading();
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    load_calibration(0);
    stall_left = 400;
    repeat (20) random_reading();
    // sender pauses until everything is back, then resumes
    wait_drained();
    repeat (20) random_reading();
    wait_drained();
  endtask

  initial begin
    s_valid = 1'b0;
    s_data = '0;
    s_user = '0;
    m_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cal_temp = '0;
    cal_press_lo = '0;
    cal_press_mid = '0;
    cal_press_hi = '0;
    cal_hum = '0;
    fine_temp = 0;
    cycles = 0;
    errors = 0;
    send_idle = 13;
    recv_idle = 57;
    stall_left = 0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed();
    test_random_phase(13, 57, 340);
    test_random_phase(57, 13, 340);
    test_random_phase(0, 0, 340);
    test_backpressure();
    if (errors == 0 && pending_readings.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
